// ----- hdl/tonego_pkg.sv -----
// ----------------------------------------------------------------------------
// tonego_pkg
// shared codes, types and reply byte tables for the telnet option negotiator
// ----------------------------------------------------------------------------
package tonego_pkg;

  // telnet command bytes
  localparam logic [7:0] CMD_IAC  = 8'hFF;
  localparam logic [7:0] CMD_DONT = 8'hFE;
  localparam logic [7:0] CMD_DO   = 8'hFD;
  localparam logic [7:0] CMD_WONT = 8'hFC;
  localparam logic [7:0] CMD_WILL = 8'hFB;
  localparam logic [7:0] CMD_SB   = 8'hFA;
  localparam logic [7:0] CMD_SE   = 8'hF0;

  // option codes and terminal-type subcodes
  localparam logic [7:0] OPT_TERM = 8'h18;
  localparam logic [7:0] OPT_FLOW = 8'h21;
  localparam logic [7:0] OPT_SGA  = 8'h03;
  localparam logic [7:0] OPT_ECHO = 8'h01;
  localparam logic [7:0] TT_SEND  = 8'h01;
  localparam logic [7:0] TT_IS    = 8'h00;

  typedef enum logic [3:0] {
    PH_DATA,
    PH_IAC,
    PH_WILL,
    PH_WONT,
    PH_DO,
    PH_DONT,
    PH_SB,
    PH_SB_IAC,
    PH_SB_TERM
  } tonego_phase_e;

  typedef enum logic [1:0] {
    FLOW_UNKNOWN,
    FLOW_DUE,
    FLOW_SENT,
    FLOW_REFUSED
  } tonego_flow_e;

  // burst segments, in emission order
  localparam int unsigned SEG_N     = 5;
  localparam int unsigned SEG_DATA  = 0;
  localparam int unsigned SEG_REPLY = 1;
  localparam int unsigned SEG_OPEN  = 2;
  localparam int unsigned SEG_FLOW  = 3;
  localparam int unsigned SEG_TERM  = 4;

  // last byte position of each segment
  localparam logic [3:0] END_DATA  = 4'd0;
  localparam logic [3:0] END_REPLY = 4'd2;
  localparam logic [3:0] END_OPEN  = 4'd11;
  localparam logic [3:0] END_FLOW  = 4'd4;
  localparam logic [3:0] END_TERM  = 4'd5;

  // what one received byte asks the emitter to send
  typedef struct packed {
    logic       data_v;
    logic [7:0] data_byte;
    logic       reply_v;
    logic [7:0] reply_cmd;
    logic [7:0] reply_opt;
    logic       open_v;
    logic       flow_v;
    logic       term_v;
  } tonego_desc_t;

  // opening offers: DO TERM, WILL SGA, DO FLOW, WILL ECHO
  function automatic logic [7:0] open_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd1:    b = CMD_DO;
      4'd2:    b = OPT_TERM;
      4'd4:    b = CMD_WILL;
      4'd5:    b = OPT_SGA;
      4'd7:    b = CMD_DO;
      4'd8:    b = OPT_FLOW;
      4'd10:   b = CMD_WILL;
      4'd11:   b = OPT_ECHO;
      default: b = CMD_IAC;
    endcase
    return b;
  endfunction

  // flow-control subnegotiation: IAC SB FLOW IAC SE
  function automatic logic [7:0] flow_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd1:    b = CMD_SB;
      4'd2:    b = OPT_FLOW;
      4'd4:    b = CMD_SE;
      default: b = CMD_IAC;
    endcase
    return b;
  endfunction

  // terminal-type request: IAC SB TERM SEND IAC SE
  function automatic logic [7:0] term_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd1:    b = CMD_SB;
      4'd2:    b = OPT_TERM;
      4'd3:    b = TT_SEND;
      4'd5:    b = CMD_SE;
      default: b = CMD_IAC;
    endcase
    return b;
  endfunction

endpackage

// ----- hdl/tonego_if.sv -----
// ----------------------------------------------------------------------------
// tonego_if
// valid/ready channels for received bytes and produced bytes
// ----------------------------------------------------------------------------
interface tonego_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       chunk_end;

  modport source (output valid, output rx_byte, output chunk_end, input ready);
  modport sink   (input valid, input rx_byte, input chunk_end, output ready);
endinterface

interface tonego_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       to_peer;
  logic       last;

  modport source (output valid, output out_byte, output to_peer, output last, input ready);
  modport sink   (input valid, input out_byte, input to_peer, input last, output ready);
endinterface

// ----- hdl/tonego_parser.sv -----
// ----------------------------------------------------------------------------
// tonego_parser
// iac sequence parser and option state, one byte per cycle while acc_i is high
// ----------------------------------------------------------------------------
module tonego_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   acc_i,
  input  logic [7:0]             rx_byte_i,
  input  logic                   chunk_end_i,
  output tonego_pkg::tonego_desc_t desc_o,
  output logic                   desc_v_o
);

  tonego_pkg::tonego_phase_e phase_q, phase_d;
  tonego_pkg::tonego_flow_e  flow_q, flow_d;
  logic will_term_q, will_term_d;
  logic will_sga_q, will_sga_d;
  logic will_echo_q, will_echo_d;
  logic opening_q, opening_d;
  logic known_q, known_d;
  logic will;

  // next parse phase
  always_comb begin
    phase_d = tonego_pkg::PH_DATA;
    case (phase_q)
      tonego_pkg::PH_DATA: begin
        phase_d = (rx_byte_i == tonego_pkg::CMD_IAC) ? tonego_pkg::PH_IAC
                                                     : tonego_pkg::PH_DATA;
      end
      tonego_pkg::PH_IAC: begin
        case (rx_byte_i)
          tonego_pkg::CMD_WILL: phase_d = tonego_pkg::PH_WILL;
          tonego_pkg::CMD_WONT: phase_d = tonego_pkg::PH_WONT;
          tonego_pkg::CMD_DO:   phase_d = tonego_pkg::PH_DO;
          tonego_pkg::CMD_DONT: phase_d = tonego_pkg::PH_DONT;
          tonego_pkg::CMD_SB:   phase_d = tonego_pkg::PH_SB;
          default:              phase_d = tonego_pkg::PH_DATA;
        endcase
      end
      tonego_pkg::PH_SB, tonego_pkg::PH_SB_TERM: begin
        if (phase_q == tonego_pkg::PH_SB_TERM && rx_byte_i == tonego_pkg::TT_IS) begin
          phase_d = tonego_pkg::PH_SB;
        end else if (rx_byte_i == tonego_pkg::CMD_IAC) begin
          phase_d = tonego_pkg::PH_SB_IAC;
        end else if (rx_byte_i == tonego_pkg::OPT_TERM) begin
          phase_d = tonego_pkg::PH_SB_TERM;
        end else begin
          phase_d = tonego_pkg::PH_SB;
        end
      end
      tonego_pkg::PH_SB_IAC: begin
        phase_d = (rx_byte_i == tonego_pkg::CMD_SE) ? tonego_pkg::PH_DATA
                                                    : tonego_pkg::PH_SB;
      end
      default: phase_d = tonego_pkg::PH_DATA;
    endcase
  end

  // option records, replies and chunk-end negotiation
  always_comb begin
    will_term_d = will_term_q;
    will_sga_d  = will_sga_q;
    will_echo_d = will_echo_q;
    flow_d      = flow_q;
    opening_d   = opening_q;
    known_d     = known_q;
    will        = (phase_q == tonego_pkg::PH_WILL);

    desc_o           = '0;
    desc_o.data_byte = rx_byte_i;
    desc_o.reply_opt = rx_byte_i;
    desc_o.reply_cmd = tonego_pkg::CMD_WONT;

    case (phase_q)
      tonego_pkg::PH_DATA: begin
        desc_o.data_v = (rx_byte_i != tonego_pkg::CMD_IAC);
      end
      tonego_pkg::PH_IAC: begin
        desc_o.data_v = (rx_byte_i == tonego_pkg::CMD_IAC);
      end
      tonego_pkg::PH_WILL, tonego_pkg::PH_WONT: begin
        case (rx_byte_i)
          tonego_pkg::OPT_TERM: will_term_d = will;
          tonego_pkg::OPT_SGA:  will_sga_d  = will;
          tonego_pkg::OPT_ECHO: will_echo_d = will;
          tonego_pkg::OPT_FLOW: flow_d = will ? tonego_pkg::FLOW_DUE
                                              : tonego_pkg::FLOW_REFUSED;
          default: ;
        endcase
      end
      tonego_pkg::PH_DO: begin
        desc_o.reply_v = 1'b1;
        if (rx_byte_i == tonego_pkg::OPT_ECHO || rx_byte_i == tonego_pkg::OPT_SGA) begin
          desc_o.reply_cmd = tonego_pkg::CMD_WILL;
        end
      end
      tonego_pkg::PH_SB_TERM: begin
        if (rx_byte_i == tonego_pkg::TT_IS) begin
          known_d = 1'b1;
        end
      end
      default: ;
    endcase

    if (chunk_end_i) begin
      desc_o.open_v = !opening_q;
      opening_d     = 1'b1;
      if (flow_d == tonego_pkg::FLOW_DUE) begin
        desc_o.flow_v = 1'b1;
        flow_d        = tonego_pkg::FLOW_SENT;
      end
      desc_o.term_v = will_term_d && !known_d;
    end
  end

  assign desc_v_o = acc_i && (desc_o.data_v || desc_o.reply_v || desc_o.open_v ||
                              desc_o.flow_v || desc_o.term_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= tonego_pkg::PH_DATA;
      flow_q      <= tonego_pkg::FLOW_UNKNOWN;
      will_term_q <= 1'b0;
      will_sga_q  <= 1'b0;
      will_echo_q <= 1'b0;
      opening_q   <= 1'b0;
      known_q     <= 1'b0;
    end else if (acc_i) begin
      phase_q     <= phase_d;
      flow_q      <= flow_d;
      will_term_q <= will_term_d;
      will_sga_q  <= will_sga_d;
      will_echo_q <= will_echo_d;
      opening_q   <= opening_d;
      known_q     <= known_d;
    end
  end

  // opening offers go out at the first chunk end only
  a_open_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && chunk_end_i && !opening_q |-> desc_v_o && desc_o.open_v)
    else $error("opening offers not issued at first chunk end");

  // a DO is always answered
  a_do_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && phase_q == tonego_pkg::PH_DO |-> desc_v_o && desc_o.reply_v)
    else $error("DO left without a reply");

  // a byte never gives both data and a reply
  a_data_or_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i |-> !(desc_o.data_v && desc_o.reply_v))
    else $error("data byte and reply from one byte");

endmodule

// ----- hdl/tonego_emitter.sv -----
// ----------------------------------------------------------------------------
// tonego_emitter
// holds one pending burst and plays the current one out a byte per cycle while tx_o.ready is high
// ----------------------------------------------------------------------------
module tonego_emitter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tonego_pkg::tonego_desc_t desc_i,
  input  logic                     desc_v_i,
  output logic                     ready_o,
  tonego_out_if.source             tx_o
);

  localparam int unsigned SegN = tonego_pkg::SEG_N;

  tonego_pkg::tonego_desc_t pend_q;
  logic                     pend_v_q, pend_v_d;
  logic [SegN-1:0]          flags_q, flags_d;
  logic [3:0]               idx_q, idx_d;
  logic [7:0]               data_q, cmd_q, opt_q;

  logic [SegN-1:0] cur_oh, rest;
  logic [3:0]      end_idx;
  logic            at_end, fire, load;
  logic [7:0]      out_byte;

  // lowest pending segment goes first
  assign cur_oh = flags_q & (~flags_q + {{(SegN-1){1'b0}}, 1'b1});
  assign rest   = flags_q & ~cur_oh;

  always_comb begin
    end_idx  = tonego_pkg::END_DATA;
    out_byte = data_q;
    case (cur_oh)
      SegN'(1) << tonego_pkg::SEG_REPLY: begin
        end_idx  = tonego_pkg::END_REPLY;
        out_byte = (idx_q == 4'd0) ? tonego_pkg::CMD_IAC
                 : (idx_q == 4'd1) ? cmd_q : opt_q;
      end
      SegN'(1) << tonego_pkg::SEG_OPEN: begin
        end_idx  = tonego_pkg::END_OPEN;
        out_byte = tonego_pkg::open_byte(idx_q);
      end
      SegN'(1) << tonego_pkg::SEG_FLOW: begin
        end_idx  = tonego_pkg::END_FLOW;
        out_byte = tonego_pkg::flow_byte(idx_q);
      end
      SegN'(1) << tonego_pkg::SEG_TERM: begin
        end_idx  = tonego_pkg::END_TERM;
        out_byte = tonego_pkg::term_byte(idx_q);
      end
      default: ;
    endcase
  end

  assign at_end        = (idx_q == end_idx);
  assign tx_o.valid    = (flags_q != '0);
  assign tx_o.out_byte = out_byte;
  assign tx_o.to_peer  = !cur_oh[tonego_pkg::SEG_DATA];
  assign tx_o.last     = at_end && (rest == '0);

  assign fire    = tx_o.valid && tx_o.ready;
  assign load    = pend_v_q && ((flags_q == '0) || (fire && tx_o.last));
  assign ready_o = !pend_v_q || load;

  always_comb begin
    flags_d  = flags_q;
    idx_d    = idx_q;
    pend_v_d = pend_v_q;
    if (fire) begin
      if (at_end) begin
        flags_d = rest;
        idx_d   = '0;
      end else begin
        idx_d = idx_q + 4'd1;
      end
    end
    if (load) begin
      flags_d[tonego_pkg::SEG_DATA]  = pend_q.data_v;
      flags_d[tonego_pkg::SEG_REPLY] = pend_q.reply_v;
      flags_d[tonego_pkg::SEG_OPEN]  = pend_q.open_v;
      flags_d[tonego_pkg::SEG_FLOW]  = pend_q.flow_v;
      flags_d[tonego_pkg::SEG_TERM]  = pend_q.term_v;
      idx_d    = '0;
      pend_v_d = 1'b0;
    end
    if (desc_v_i && ready_o) begin
      pend_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q  <= '0;
      idx_q    <= '0;
      pend_v_q <= 1'b0;
    end else begin
      flags_q  <= flags_d;
      idx_q    <= idx_d;
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (desc_v_i && ready_o) begin
      pend_q <= desc_i;
    end
    if (load) begin
      data_q <= pend_q.data_byte;
      cmd_q  <= pend_q.reply_cmd;
      opt_q  <= pend_q.reply_opt;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flags_q != '0 |-> idx_q <= end_idx)
    else $error("burst index beyond its segment");

  a_pend_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q && !load |=> pend_v_q)
    else $error("pending burst lost");

  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && tx_o.last && !pend_v_q |=> !tx_o.valid)
    else $error("output valid with nothing queued");

endmodule

// ----- hdl/telnet_option_negotiator_top.sv -----
// ----------------------------------------------------------------------------
// telnet_option_negotiator_top
// path: a byte's first result passes the pending burst register and then the
// burst flags before it is valid, when the output is idle
// throughput: one received byte per cycle while each gives at most one result and the output is ready
// a byte can give up to 26 results, and the output is held until all are taken
// reset (async, active low) returns to the data phase with all options cleared
// ----------------------------------------------------------------------------
module telnet_option_negotiator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  tonego_in_if.sink    rx_i,
  tonego_out_if.source tx_o
);

  // a received byte is taken when the pending burst slot is free or drains now
  logic                     in_ready;
  logic                     acc;
  tonego_pkg::tonego_desc_t desc;
  logic                     desc_v;

  assign rx_i.ready = in_ready;
  assign acc        = rx_i.valid && in_ready;

  // parser: updates phase and option state on every accepted byte and
  // describes the burst this byte causes (data, reply, chunk-end offers)
  tonego_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .rx_byte_i   (rx_i.rx_byte),
    .chunk_end_i (rx_i.chunk_end),
    .desc_o      (desc),
    .desc_v_o    (desc_v)
  );

  // emitter: one pending burst plus the one in flight, so the parser can take
  // a byte while the results of the last one wait on the output side
  tonego_emitter u_emitter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .desc_i   (desc),
    .desc_v_i (desc_v),
    .ready_o  (in_ready),
    .tx_o     (tx_o)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the telnet option negotiator: a queue-fed byte
// driver and a result monitor around an in-bench model of the iac parser and
// its chunk-end negotiation, with random idling on both channels
// ----------------------------------------------------------------------------
module tb_top;

  // one received byte as the driver sends it; hold waits for a drained output
  typedef struct packed {
    logic [7:0] b;
    logic       ce;
    logic       hold;
  } rx_item_t;

  // one produced byte as the monitor sees it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       to_peer;
    logic       last;
  } tx_beat_t;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       live      = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_end    = 1'b0;
  logic       out_ready = 1'b0;
  logic       rx_fire   = 1'b0;

  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  int unsigned mismatch_cnt = 0;

  rx_item_t rx_pending[$];   // bytes still to be sent
  tx_beat_t due_bytes[$];    // bytes the block owes us, oldest first
  tx_beat_t burst_q[$];      // scratch: what one received byte gives

  // negotiator state as the bench tracks it
  tonego_pkg::tonego_phase_e ph          = tonego_pkg::PH_DATA;
  logic                      peer_term   = 1'b0;
  logic                      peer_sga    = 1'b0;
  logic                      peer_echo   = 1'b0;
  tonego_pkg::tonego_flow_e  flow        = tonego_pkg::FLOW_UNKNOWN;
  logic                      offers_sent = 1'b0;
  logic                      term_known  = 1'b0;

  tonego_in_if  rx ();
  tonego_out_if tx ();

  assign rx.valid     = in_valid;
  assign rx.rx_byte   = in_byte;
  assign rx.chunk_end = in_end;
  assign tx.ready     = out_ready;

  telnet_option_negotiator_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .tx_o   (tx)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // byte model
  // ------------------------------------------------------------------------
  task automatic add_beat(input logic [7:0] b, input logic peer);
    tx_beat_t beat;
    beat.out_byte = b;
    beat.to_peer  = peer;
    beat.last     = 1'b0;
    burst_q = {burst_q, beat};
  endtask

  // three-byte command towards the peer
  task automatic add_cmd(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
    add_beat(a, 1'b1);
    add_beat(b, 1'b1);
    add_beat(c, 1'b1);
  endtask

  // peer WILL/WONT for the options we track, anything else is ignored
  task automatic note_option(input logic [7:0] opt, input logic will);
    if (opt == tonego_pkg::OPT_TERM) begin
      peer_term = will;
    end else if (opt == tonego_pkg::OPT_SGA) begin
      peer_sga = will;
    end else if (opt == tonego_pkg::OPT_ECHO) begin
      peer_echo = will;
    end else if (opt == tonego_pkg::OPT_FLOW) begin
      flow = will ? tonego_pkg::FLOW_DUE : tonego_pkg::FLOW_REFUSED;
    end
  endtask

  // advance the parser by one byte and queue every byte it should produce
  task automatic parse_rx_byte(input logic [7:0] b, input logic ce);
    tx_beat_t beat;
    burst_q.delete();
    case (ph)
      tonego_pkg::PH_DATA: begin
        if (b == tonego_pkg::CMD_IAC) ph = tonego_pkg::PH_IAC;
        else add_beat(b, 1'b0);
      end
      tonego_pkg::PH_IAC: begin
        if (b == tonego_pkg::CMD_WILL) ph = tonego_pkg::PH_WILL;
        else if (b == tonego_pkg::CMD_WONT) ph = tonego_pkg::PH_WONT;
        else if (b == tonego_pkg::CMD_DO) ph = tonego_pkg::PH_DO;
        else if (b == tonego_pkg::CMD_DONT) ph = tonego_pkg::PH_DONT;
        else if (b == tonego_pkg::CMD_SB) ph = tonego_pkg::PH_SB;
        else begin
          // doubled iac is a literal 0xff, any other command is dropped
          if (b == tonego_pkg::CMD_IAC) add_beat(b, 1'b0);
          ph = tonego_pkg::PH_DATA;
        end
      end
      tonego_pkg::PH_WILL: begin
        note_option(b, 1'b1);
        ph = tonego_pkg::PH_DATA;
      end
      tonego_pkg::PH_WONT: begin
        note_option(b, 1'b0);
        ph = tonego_pkg::PH_DATA;
      end
      tonego_pkg::PH_DO: begin
        if (b == tonego_pkg::OPT_ECHO)
          add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_WILL, tonego_pkg::OPT_ECHO);
        else if (b == tonego_pkg::OPT_SGA)
          add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_WILL, tonego_pkg::OPT_SGA);
        else
          add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_WONT, b);
        ph = tonego_pkg::PH_DATA;
      end
      tonego_pkg::PH_DONT: ph = tonego_pkg::PH_DATA;
      tonego_pkg::PH_SB, tonego_pkg::PH_SB_TERM: begin
        if (ph == tonego_pkg::PH_SB_TERM && b == tonego_pkg::TT_IS) begin
          term_known = 1'b1;
          ph = tonego_pkg::PH_SB;
        end else if (b == tonego_pkg::CMD_IAC) begin
          ph = tonego_pkg::PH_SB_IAC;
        end else if (b == tonego_pkg::OPT_TERM) begin
          ph = tonego_pkg::PH_SB_TERM;
        end else begin
          ph = tonego_pkg::PH_SB;
        end
      end
      tonego_pkg::PH_SB_IAC:
        ph = (b == tonego_pkg::CMD_SE) ? tonego_pkg::PH_DATA : tonego_pkg::PH_SB;
      default: ph = tonego_pkg::PH_DATA;
    endcase

    // chunk end: opening offers once, flow request once after each peer WILL FLOW,
    // terminal request while the peer offers it and until it has told us its type
    if (ce) begin
      if (!offers_sent) begin
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_DO, tonego_pkg::OPT_TERM);
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_WILL, tonego_pkg::OPT_SGA);
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_DO, tonego_pkg::OPT_FLOW);
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_WILL, tonego_pkg::OPT_ECHO);
        offers_sent = 1'b1;
      end
      if (flow == tonego_pkg::FLOW_DUE) begin
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_SB, tonego_pkg::OPT_FLOW);
        add_beat(tonego_pkg::CMD_IAC, 1'b1);
        add_beat(tonego_pkg::CMD_SE, 1'b1);
        flow = tonego_pkg::FLOW_SENT;
      end
      if (peer_term && !term_known) begin
        add_cmd(tonego_pkg::CMD_IAC, tonego_pkg::CMD_SB, tonego_pkg::OPT_TERM);
        add_cmd(tonego_pkg::TT_SEND, tonego_pkg::CMD_IAC, tonego_pkg::CMD_SE);
      end
    end

    foreach (burst_q[i]) begin
      beat      = burst_q[i];
      beat.last = (i == burst_q.size() - 1);
      due_bytes = {due_bytes, beat};
    end
  endtask

  // ------------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------------
  task automatic add_rx(input logic [7:0] b, input logic ce);
    rx_item_t item;
    item.b    = b;
    item.ce   = ce;
    item.hold = 1'b0;
    rx_pending = {rx_pending, item};
  endtask

  function automatic logic coin_end();
    return ($urandom_range(0, 5) == 0);
  endfunction

  // mostly the tracked options, sometimes anything
  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 4))
      0:       return tonego_pkg::OPT_TERM;
      1:       return tonego_pkg::OPT_SGA;
      2:       return tonego_pkg::OPT_ECHO;
      3:       return tonego_pkg::OPT_FLOW;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // sender: next byte goes out on the falling edge once the slot is free
  // ------------------------------------------------------------------------
  always @(negedge clk_i) begin
    rx_item_t item;
    if (live && (!in_valid || rx_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (rx_pending.size() == 0) begin
        in_valid <= 1'b0;
      end else if (rx_pending[0].hold && due_bytes.size() != 0) begin
        // hold-off: let the output drain completely first
        in_valid <= 1'b0;
      end else if (rx_pending.size() > 40 && $urandom_range(0, 9) == 0) begin
        // start an idle burst
        send_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else begin
        item = rx_pending.pop_front();
        in_valid <= 1'b1;
        in_byte  <= item.b;
        in_end   <= item.ce;
      end
    end
  end

  // receiver: random stall bursts, none once the stimulus is nearly done
  always @(negedge clk_i) begin
    if (live) begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else if (rx_pending.size() > 40 && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 18);
        out_ready  <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor: predict on input transactions, check output transactions
  // ------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tx_beat_t want;
    live    <= rst_ni;
    rx_fire <= rst_ni && in_valid && rx.ready;
    if (rst_ni && in_valid && rx.ready) parse_rx_byte(in_byte, in_end);
    if (rst_ni && tx.valid && out_ready) begin
      if (due_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("%0t: unexpected result byte %h to_peer %b last %b",
                   $time, tx.out_byte, tx.to_peer, tx.last);
      end else begin
        want = due_bytes.pop_front();
        if (tx.out_byte !== want.out_byte || tx.to_peer !== want.to_peer ||
            tx.last !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: mismatch, expected byte %h to_peer %b last %b, got %h %b %b",
                     $time, want.out_byte, want.to_peer, want.last,
                     tx.out_byte, tx.to_peer, tx.last);
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // stimulus and end of run
  // ------------------------------------------------------------------------
  initial begin
    int unsigned target;
    int unsigned n_body;
    logic [7:0]  cmd;
    rx_item_t    item;

    // peer offers flow control and terminal type, then a DO of an unknown
    // option at the first chunk end: reply, offers, flow and terminal request
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_WILL, 1'b0);
    add_rx(tonego_pkg::OPT_FLOW, 1'b0);
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_WILL, 1'b0);
    add_rx(tonego_pkg::OPT_TERM, 1'b0);
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_DO, 1'b0);
    add_rx(8'h05, 1'b1);
    // doubled iac as data, terminal request repeated at chunk end
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_IAC, 1'b1);
    // dont is swallowed, unknown command is dropped
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_DONT, 1'b0);
    add_rx(tonego_pkg::OPT_ECHO, 1'b0);
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(8'h07, 1'b0);
    // subnegotiation with an iac that is not SE inside, no terminal reply
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_SB, 1'b0);
    add_rx(tonego_pkg::OPT_TERM, 1'b0);
    add_rx(tonego_pkg::TT_SEND, 1'b0); add_rx(tonego_pkg::CMD_IAC, 1'b0);
    add_rx(8'h01, 1'b0);
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_SE, 1'b1);

    target = rx_pending.size() + 220;
    while (rx_pending.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1: add_rx(8'($urandom_range(0, 254)), coin_end());
        2: begin
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(tonego_pkg::CMD_IAC, coin_end());
        end
        3: begin
          cmd = ($urandom_range(0, 1) == 0) ? tonego_pkg::CMD_WILL : tonego_pkg::CMD_WONT;
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(cmd, 1'b0);
          add_rx(pick_option(), coin_end());
        end
        4: begin
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(tonego_pkg::CMD_DO, 1'b0);
          add_rx(pick_option(), coin_end());
        end
        5: begin
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(tonego_pkg::CMD_DONT, 1'b0);
          add_rx(8'($urandom_range(0, 255)), coin_end());
        end
        6: begin
          // command byte below SB: dropped
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(8'($urandom_range(0, 8'hF9)), coin_end());
        end
        7, 8: begin
          // subnegotiation body that never carries a terminal reply
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(tonego_pkg::CMD_SB, 1'b0);
          n_body = $urandom_range(0, 5);
          for (int k = 0; k < n_body; k++) begin
            case ($urandom_range(0, 2))
              0: begin
                add_rx(tonego_pkg::OPT_TERM, 1'b0);
                add_rx(8'($urandom_range(1, 8'hFE)), coin_end());
              end
              1: begin
                add_rx(tonego_pkg::CMD_IAC, 1'b0);
                add_rx(8'($urandom_range(0, 8'hEF)), coin_end());
              end
              default: add_rx(8'($urandom_range(8'h19, 8'hFE)), coin_end());
            endcase
          end
          add_rx(tonego_pkg::CMD_IAC, 1'b0);
          add_rx(tonego_pkg::CMD_SE, coin_end());
        end
        default: begin
          repeat ($urandom_range(1, 3)) add_rx(8'($urandom_range(0, 255)), coin_end());
        end
      endcase
    end

    // two points where the sender waits for an empty output
    item = rx_pending[120];
    item.hold = 1'b1;
    rx_pending[120] = item;
    item = rx_pending[200];
    item.hold = 1'b1;
    rx_pending[200] = item;

    // terminal reply closes the run; a later WILL TERM asks nothing more
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_SB, 1'b0);
    add_rx(tonego_pkg::OPT_TERM, 1'b0);
    add_rx(tonego_pkg::TT_IS, 1'b0);   add_rx(tonego_pkg::CMD_IAC, 1'b0);
    add_rx(tonego_pkg::CMD_SE, 1'b0);
    add_rx(tonego_pkg::CMD_IAC, 1'b0); add_rx(tonego_pkg::CMD_WILL, 1'b0);
    add_rx(tonego_pkg::OPT_TERM, 1'b1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (rx_pending.size() != 0 || in_valid) @(posedge clk_i);
    while (due_bytes.size() != 0) @(posedge clk_i);
    // catch any stray result after the last expected one
    repeat (40) @(posedge clk_i);

    if (due_bytes.size() != 0)
      $display("%0d expected results never arrived", due_bytes.size());
    if (mismatch_cnt == 0 && due_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tonego_pkg.sv
hdl/tonego_if.sv
hdl/tonego_parser.sv
hdl/tonego_emitter.sv
hdl/telnet_option_negotiator_top.sv
verif/tb_top.sv
